FILE: sv/rof2d_pkg.sv
package rof2d_pkg;
    localparam int MaxWidth   = 256;
    localparam int MaxHeight  = 256;
    localparam int MaxWindow  = 7;
    localparam int CoordW     = $clog2(MaxWidth);
    localparam int RowW       = $clog2(MaxHeight);
    localparam int AddrW      = CoordW + RowW;
    localparam int PosW       = 17;
    localparam int RankCntW   = $clog2(MaxWindow * MaxWindow + 1);
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_WINDOW = 2'd2,
        REG_MODE   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_MIN = 2'd0,
        MODE_MED = 2'd1,
        MODE_MAX = 2'd2
    } t_mode;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EMIT = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_COUNT,
        ST_DONE
    } t_state;

    // One word handed from the front to the back, kept in arrival order.
    typedef struct packed {
        t_op              op;
        logic [AddrW-1:0] pos;
        logic [7:0]       pixel;
        logic             last;
        logic             err;
    } t_job;
endpackage

FILE: sv/rof2d_front.sv
module rof2d_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_operation,
    input  logic [7:0]      i_pixel_in,
    input  logic [8:0]      i_width,
    input  logic [8:0]      i_height,
    input  logic [2:0]      i_window,
    output logic            o_job_valid,
    input  logic            i_job_ready,
    output rof2d_pkg::t_job o_job
);
    import rof2d_pkg::*;

    logic [PosW-1:0] r_ld_pos, r_em_pos;
    logic [8:0]      w_eff, h_eff;
    logic [PosW-1:0] total, ld_pos, em_pos, ld_next, em_next;
    logic            is_emit, take;

    // Sizes outside 1..256 are clamped; zero acts as one.
    assign w_eff = (i_width == 9'd0) ? 9'd1 :
                   (i_width > 9'(MaxWidth)) ? 9'(MaxWidth) : i_width;
    assign h_eff = (i_height == 9'd0) ? 9'd1 :
                   (i_height > 9'(MaxHeight)) ? 9'(MaxHeight) : i_height;
    assign total = {8'd0, w_eff} * {8'd0, h_eff};

    // A position left beyond the frame after a size change restarts at zero.
    assign ld_pos  = (r_ld_pos < total) ? r_ld_pos : '0;
    assign em_pos  = (r_em_pos < total) ? r_em_pos : '0;
    assign ld_next = ld_pos + PosW'(1);
    assign em_next = em_pos + PosW'(1);

    assign is_emit = (t_op'(i_operation) == OP_EMIT);
    assign take    = i_valid && i_job_ready;

    assign o_ready     = i_job_ready;
    assign o_job_valid = i_valid;
    assign o_job.op    = t_op'(i_operation);
    assign o_job.pos   = is_emit ? em_pos[AddrW-1:0] : ld_pos[AddrW-1:0];
    assign o_job.pixel = i_pixel_in;
    assign o_job.last  = (em_next >= total);
    assign o_job.err   = !i_window[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_pos <= '0;
            r_em_pos <= '0;
        end else if (take) begin
            if (is_emit) begin
                r_em_pos <= (em_next >= total) ? '0 : em_next;
            end else begin
                r_ld_pos <= (ld_next >= total) ? '0 : ld_next;
            end
        end
    end
endmodule

FILE: sv/rof2d_queue.sv
module rof2d_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rof2d_pkg::t_job i_job,
    output logic            o_valid,
    input  logic            i_ready,
    output rof2d_pkg::t_job o_job
);
    import rof2d_pkg::*;

    t_job r_mem [QueueDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 2'(QueueDepth));
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

FILE: sv/rof2d_back.sv
module rof2d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [8:0]      i_width,
    input  logic [8:0]      i_height,
    input  logic [2:0]      i_window,
    input  logic [1:0]      i_mode,
    input  logic            i_job_valid,
    output logic            o_job_ready,
    input  rof2d_pkg::t_job i_job,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_pixel_out,
    output logic            o_last_pixel,
    output logic            o_size_error
);
    import rof2d_pkg::*;

    logic [7:0] r_mem [2**AddrW];
    logic [7:0] r_rd;

    t_state r_state, n_state;
    t_job   r_job;
    logic [AddrW-1:0] r_quo;         // row of the pixel once the division ends
    logic [8:0]       r_rem;         // column of the pixel once the division ends
    logic [3:0]       r_div_cnt;
    logic [2:0] r_dr, r_dc;          // window offsets 0..side-1
    logic [2:0] r_side;
    logic [RankCntW-1:0] r_k;        // target rank (0-based)
    logic [RankCntW-1:0] r_below;    // count of window values < mid
    logic [7:0] r_lo, r_hi;
    logic [7:0] r_out;
    logic [2:0] r_pass;
    logic       r_rd_vld, r_sweep_end, r_ov;

    logic [8:0] w_eff, h_eff;
    logic [CoordW-1:0] w_max, h_max;
    assign w_eff = (i_width == 9'd0) ? 9'd1 :
                   (i_width > 9'(MaxWidth)) ? 9'(MaxWidth) : i_width;
    assign h_eff = (i_height == 9'd0) ? 9'd1 :
                   (i_height > 9'(MaxHeight)) ? 9'(MaxHeight) : i_height;
    assign w_max = CoordW'(w_eff - 9'd1);
    assign h_max = CoordW'(h_eff - 9'd1);

    logic [2:0] side;
    logic [RankCntW-1:0] n_taps;
    assign side   = (i_window > 3'(MaxWindow)) ? 3'(MaxWindow) : i_window;
    assign n_taps = RankCntW'(side) * RankCntW'(side);

    // Restoring division of the raster position by the width, one bit a cycle.
    logic [9:0] div_sh, div_diff;
    logic       div_ge;
    assign div_sh   = {r_rem, r_job.pos[r_div_cnt]};
    assign div_ge   = (div_sh >= {1'b0, w_eff});
    assign div_diff = div_sh - {1'b0, w_eff};

    // Clamped window coordinates.
    logic signed [CoordW+1:0] rr, cc;
    logic [CoordW-1:0] rc, ccl;
    logic [AddrW-1:0]  rd_addr;
    assign rr  = $signed({2'b00, r_quo[CoordW-1:0]}) + $signed({{(CoordW-1){1'b0}}, r_dr})
                 - $signed({{(CoordW-1){1'b0}}, r_side >> 1});
    assign cc  = $signed({2'b00, r_rem[CoordW-1:0]}) + $signed({{(CoordW-1){1'b0}}, r_dc})
                 - $signed({{(CoordW-1){1'b0}}, r_side >> 1});
    assign rc  = (rr < 0) ? '0 : (rr > $signed({2'b00, h_max})) ? h_max : rr[CoordW-1:0];
    assign ccl = (cc < 0) ? '0 : (cc > $signed({2'b00, w_max})) ? w_max : cc[CoordW-1:0];
    assign rd_addr = {8'd0, rc} * {7'd0, w_eff} + {8'd0, ccl};

    logic rd_en, last_tap, pass_end, ld_fire, dn_fire;
    assign rd_en    = (r_state == ST_COUNT) && !r_sweep_end;
    assign last_tap = (r_dr == r_side - 3'd1) && (r_dc == r_side - 3'd1);
    assign pass_end = r_sweep_end && !r_rd_vld;
    assign ld_fire  = (r_state == ST_IDLE) && i_job_valid && (i_job.op == OP_LOAD);
    assign dn_fire  = (r_state == ST_DONE) && (!r_ov || i_ready);

    always_ff @(posedge i_clk) begin
        if (ld_fire) r_mem[i_job.pos] <= i_job.pixel;
        r_rd <= r_mem[rd_addr];
    end

    // The rank is found by bisection on the value: each pass over the window
    // counts the pixels below a candidate; eight passes settle the answer.
    logic [7:0] mid;
    assign mid = 8'((({1'b0, r_lo} + {1'b0, r_hi}) + 9'd1) >> 1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_job_valid && i_job.op == OP_EMIT)
                          n_state = i_job.err ? ST_DONE : ST_DIV;
            ST_DIV:   if (r_div_cnt == 4'd0) n_state = ST_COUNT;
            ST_COUNT: if (pass_end && r_pass == 3'd7) n_state = ST_DONE;
            ST_DONE:  if (!r_ov || i_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    assign o_job_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ov     <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (dn_fire) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_job       <= i_job;
                r_side      <= side;
                r_dr        <= '0;
                r_dc        <= '0;
                r_lo        <= 8'd0;
                r_hi        <= 8'd255;
                r_pass      <= '0;
                r_below     <= '0;
                r_sweep_end <= 1'b0;
                r_out       <= 8'd0;
                r_quo       <= '0;
                r_rem       <= '0;
                r_div_cnt   <= 4'd15;
                case (i_mode)
                    MODE_MIN: r_k <= '0;
                    MODE_MED: r_k <= (n_taps - RankCntW'(1)) >> 1;
                    default:  r_k <= n_taps - RankCntW'(1);
                endcase
            end
            ST_DIV: begin
                r_quo     <= {r_quo[AddrW-2:0], div_ge};
                r_rem     <= div_ge ? div_diff[8:0] : div_sh[8:0];
                r_div_cnt <= r_div_cnt - 4'd1;
            end
            ST_COUNT: begin
                if (!r_sweep_end) begin
                    if (last_tap) r_sweep_end <= 1'b1;
                    else if (r_dc == r_side - 3'd1) begin
                        r_dc <= '0;
                        r_dr <= r_dr + 3'd1;
                    end else r_dc <= r_dc + 3'd1;
                end
                if (r_rd_vld && r_rd < mid) r_below <= r_below + RankCntW'(1);
                if (pass_end) begin
                    // More than k values below mid: answer lies under mid.
                    if (r_below > r_k) begin
                        r_hi  <= mid - 8'd1;
                        r_out <= mid - 8'd1;
                    end else begin
                        r_lo  <= mid;
                        r_out <= mid;
                    end
                    r_pass      <= r_pass + 3'd1;
                    r_below     <= '0;
                    r_dr        <= '0;
                    r_dc        <= '0;
                    r_sweep_end <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (dn_fire) begin
            o_pixel_out  <= r_job.err ? 8'd0 : r_out;
            o_last_pixel <= r_job.last;
            o_size_error <= r_job.err;
        end
    end
    assign o_valid = r_ov;
endmodule

FILE: sv/rank_order_filter_2d_unit.sv
// Rank-order filter over a stored grayscale frame of up to 256 x 256 pixels.
// Input channel: i_valid/o_ready carry one word with i_operation and
// i_pixel_in. A load word (operation 0) stores the next pixel in raster order;
// an emit word (operation 1) asks for the next filtered pixel in raster order.
// The front gives each word its frame position and passes it through a
// two-entry queue to the engine, which carries out the words strictly in order.
// Output channel: o_valid/i_ready carry pixel_out, last_pixel, size_error.
// A load is written to the frame store when the idle engine takes it. An
// emit first splits its position into row and column, then finds the min,
// median or max by value bisection: eight passes over the side x side window
// at one frame-store read per cycle. The engine works on one word at a time
// and takes the next only once the result of an emit has been registered on
// the output.
// An even window size skips the division and search and answers with size_error set.
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
// write it only while no word is in flight.
// Reset clears positions, queue and control state and restores the register
// defaults; the frame store holds no defined data until loaded.
// When the receiver stalls, the result is held; the engine may finish one
// more emit and then waits, the queue fills and input words are refused.
module rank_order_filter_2d_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_operation,
    input  logic [7:0] i_pixel_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_pixel_out,
    output logic       o_last_pixel,
    output logic       o_size_error,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);
    import rof2d_pkg::*;

    logic [8:0] r_width, r_height;
    logic [2:0] r_window;
    logic [1:0] r_mode;
    logic       fq_valid, fq_ready, qb_valid, qb_ready;
    t_job       fq_job, qb_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
            r_window <= 3'd3;
            r_mode   <= MODE_MED;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                REG_WINDOW: r_window <= i_cfg_data[2:0];
                REG_MODE:   r_mode   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    rof2d_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_operation, .i_pixel_in,
        .i_width(r_width), .i_height(r_height), .i_window(r_window),
        .o_job_valid(fq_valid), .i_job_ready(fq_ready), .o_job(fq_job)
    );

    rof2d_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(fq_valid), .o_ready(fq_ready), .i_job(fq_job),
        .o_valid(qb_valid), .i_ready(qb_ready), .o_job(qb_job)
    );

    rof2d_back u_back (
        .i_clk, .i_rst_n,
        .i_width(r_width), .i_height(r_height), .i_window(r_window), .i_mode(r_mode),
        .i_job_valid(qb_valid), .o_job_ready(qb_ready), .i_job(qb_job),
        .o_valid, .i_ready, .o_pixel_out, .o_last_pixel, .o_size_error
    );
endmodule

FILE: sv/rof2d_checker.sv
module rof2d_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_pixel_out,
    input logic       o_size_error,
    input logic       o_cfg_ready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_out))
        else $error("output word dropped under stall");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_size_error |-> o_pixel_out == 8'd0)
        else $error("refused window carries a pixel");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port stalled");
endmodule

bind rank_order_filter_2d_unit rof2d_checker u_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_pixel_out, .o_size_error, .o_cfg_ready
);
